FILE: rtl/sprite_draw_order_list_top_assert.svh
// Assertion helpers for the draw-order list.
// Clocked checks sample on clk and hold off while rst_n is low.
`ifndef SPRITE_DRAW_ORDER_LIST_TOP_ASSERT_SVH
`define SPRITE_DRAW_ORDER_LIST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SDOL_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDOL_CHECK_SEQ(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SDOL_CHECK(lbl, prop, msg)
`define SDOL_CHECK_SEQ(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/sdol_pkg.sv
package sdol_pkg;

  localparam int SLOT_W  = 6;
  localparam int TEX_W   = 5;
  localparam int LAYER_W = 16;
  localparam int SEQ_W   = 32;
  localparam int TEXTURES = 32;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_UPDATE = 3'd1,
    OP_SETTEX = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_DRAW   = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INSERT,
    C_REMOVE,
    C_SETTEX,
    C_ROTATE,
    C_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD,
    S_DRAW
  } state_t;

  // one list position: a used slot with all of its fields
  typedef struct packed {
    logic                      vld;
    logic [SLOT_W-1:0]         slot;
    logic signed [LAYER_W-1:0] layer;
    logic [SEQ_W-1:0]          seq;
    logic [TEX_W-1:0]          tex;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] sel;   // slot looked up / edited
    entry_t            ins;   // entry to insert, tex also for set texture
  } cell_cmd_t;

  // fields of the cell whose slot matches sel
  typedef struct packed {
    logic                      hit;
    logic signed [LAYER_W-1:0] layer;
    logic [SEQ_W-1:0]          seq;
    logic [TEX_W-1:0]          tex;
  } lookup_t;

  // a sorts strictly before b: lower layer, then lower sequence
  function automatic logic key_before(input logic signed [LAYER_W-1:0] la,
                                      input logic [SEQ_W-1:0] sa,
                                      input logic signed [LAYER_W-1:0] lb,
                                      input logic [SEQ_W-1:0] sb);
    logic r;
    if (la != lb) begin
      r = (la < lb);
    end else begin
      r = (sa < sb);
    end
    return r;
  endfunction

endpackage

FILE: rtl/sprite_draw_order_list_top.sv
// Sprite draw-order list. Keeps up to SLOTS sprites sorted by signed layer,
// ties going to the earlier add (32-bit sequence stamp, compared unsigned, so
// age ordering is lost once the stamp wraps). One input word carries an
// opcode: add (takes the lowest free slot, returns it in out_slot_out),
// update layer, set texture, remove, clear and draw. Every opcode gives one
// result word with out_last set, except draw of a non-empty list, which
// streams one word per entry in draw order with out_last on the final one.
// Bad slot, unused slot, texture out of range, full table on add and unknown
// opcodes give status failed and leave the state alone; draw of an empty
// list gives status empty. Layout: the list lives in a row of cells, one per
// list position, and every insert, remove or rotate moves the whole row at
// once. Add, set texture, remove, clear, an empty draw and an update that
// keeps the layer are accepted, then done in the command state; an update
// that moves the sprite is removed there and re-inserted in S_UPD; a draw
// starts its stream in the command state, then emits one word per entry,
// the row rotating once per emitted word so the list is intact afterwards.
// A stalled output holds the command state until the result register
// frees up. No item is taken while one is in progress.
`include "sprite_draw_order_list_top_assert.svh"

module sprite_draw_order_list_top #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [5:0]  in_slot_in,
  input  logic [4:0]  in_texture_in,
  input  logic signed [15:0] in_layer_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic [4:0]  out_texture_out,
  output logic signed [15:0] out_layer_out,
  output logic        out_last
);
  import sdol_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);

  // latched command word
  logic [2:0]                op_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [TEX_W-1:0]          tex_r;
  logic signed [LAYER_W-1:0] layer_r;

  state_t            state_r, state_nxt;
  logic [SLOTS-1:0]  used_r, used_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic [SEQ_W-1:0]  nseq_r, nseq_nxt;
  logic [IDXW-1:0]   drw_r, drw_nxt;
  logic [SEQ_W-1:0]  old_seq_r;
  logic [TEX_W-1:0]  old_tex_r;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]         out_slot_r, out_slot_nxt;
  logic [TEX_W-1:0]          out_tex_r, out_tex_nxt;
  logic signed [LAYER_W-1:0] out_layer_r, out_layer_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      res_load;

  cell_cmd_t cmd;
  entry_t    head;
  lookup_t   look;

  logic            in_take;
  logic            adv;       // result register can take a word
  logic            slot_ok;
  logic            tex_ok;
  logic            full;
  logic            moved;     // update changes the layer
  logic            draw_end;
  logic [IDXW-1:0] free_idx;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign adv      = !out_valid_r || !out_stall;

  assign slot_ok  = ({1'b0, slot_r} < (SLOT_W+1)'(SLOTS)) && used_r[slot_r[IDXW-1:0]];
  assign tex_ok   = (32'(tex_r) < 32'(TEXTURES));
  assign full     = (count_r == CNTW'(SLOTS));
  assign moved    = (look.layer != layer_r);
  assign draw_end = ((CNTW'(drw_r) + CNTW'(1)) == count_r);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDXW'(i);
      end
    end
  end

  sdol_chain #(.SLOTS(SLOTS)) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (cmd),
    .head_o(head),
    .look_o(look)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (adv) begin
          if (op_r == OP_UPDATE && slot_ok && moved) begin
            state_nxt = S_UPD;
          end else if (op_r == OP_DRAW && count_r != '0) begin
            state_nxt = S_DRAW;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
      end
      S_DRAW: begin
        if (adv && draw_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // commands, bookkeeping and result words
  always_comb begin
    cmd            = '0;
    cmd.op         = C_HOLD;
    cmd.sel        = slot_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    nseq_nxt       = nseq_r;
    drw_nxt        = drw_r;
    res_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_slot_nxt   = '0;
    out_tex_nxt    = '0;
    out_layer_nxt  = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_LOOK: begin
        if (adv) begin
          res_load = 1'b1;
          drw_nxt  = '0;
          case (op_r)
            OP_ADD: begin
              if (tex_ok && !full) begin
                cmd.op    = C_INSERT;
                cmd.ins   = '{vld: 1'b1, slot: SLOT_W'(free_idx), layer: layer_r,
                              seq: nseq_r, tex: tex_r};
                used_nxt[free_idx] = 1'b1;
                count_nxt = count_r + CNTW'(1);
                nseq_nxt  = nseq_r + SEQ_W'(1);
                out_slot_nxt = SLOT_W'(free_idx);
              end else begin
                out_status_nxt = ST_FAIL;
              end
            end
            OP_UPDATE: begin
              if (slot_ok) begin
                if (moved) begin
                  cmd.op = C_REMOVE;
                end
              end else begin
                out_status_nxt = ST_FAIL;
              end
            end
            OP_SETTEX: begin
              if (slot_ok && tex_ok) begin
                cmd.op      = C_SETTEX;
                cmd.ins.tex = tex_r;
              end else begin
                out_status_nxt = ST_FAIL;
              end
            end
            OP_REMOVE: begin
              if (slot_ok) begin
                cmd.op    = C_REMOVE;
                used_nxt[slot_r[IDXW-1:0]] = 1'b0;
                count_nxt = count_r - CNTW'(1);
              end else begin
                out_status_nxt = ST_FAIL;
              end
            end
            OP_CLEAR: begin
              cmd.op    = C_CLEAR;
              used_nxt  = '0;
              count_nxt = '0;
              nseq_nxt  = '0;
            end
            OP_DRAW: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                res_load = 1'b0;
              end
            end
            default: begin
              out_status_nxt = ST_FAIL;
            end
          endcase
        end
      end
      S_UPD: begin
        // re-insert under the new layer, keeping stamp and texture
        cmd.op  = C_INSERT;
        cmd.ins = '{vld: 1'b1, slot: slot_r, layer: layer_r,
                    seq: old_seq_r, tex: old_tex_r};
      end
      S_DRAW: begin
        if (adv) begin
          cmd.op        = C_ROTATE;
          res_load      = 1'b1;
          out_slot_nxt  = head.slot;
          out_tex_nxt   = head.tex;
          out_layer_nxt = head.layer;
          out_last_nxt  = draw_end;
          drw_nxt       = drw_r + IDXW'(1);
        end
      end
      default: begin
        cmd.op = C_HOLD;
      end
    endcase
  end

  assign out_valid_nxt = res_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      nseq_r      <= '0;
      drw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      nseq_r      <= nseq_nxt;
      drw_r       <= drw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r    <= in_opcode;
      slot_r  <= in_slot_in;
      tex_r   <= in_texture_in;
      layer_r <= in_layer_in;
    end
    if (state_r == S_LOOK) begin
      old_seq_r <= look.seq;
      old_tex_r <= look.tex;
    end
    if (res_load) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_tex_r    <= out_tex_nxt;
      out_layer_r  <= out_layer_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_out    = out_slot_r;
  assign out_texture_out = out_tex_r;
  assign out_layer_out   = out_layer_r;
  assign out_last        = out_last_r;

  // list length tracks the slot table
  `SDOL_CHECK(a_count_used, count_r == CNTW'($countones(used_r)), "list count off from used slots")
  `SDOL_CHECK(a_count_max, count_r <= CNTW'(SLOTS), "list count beyond table size")
  `SDOL_CHECK_SEQ(a_take_look, in_take, state_r == S_LOOK, "accepted word not decoded")
  `SDOL_CHECK_SEQ(a_upd_done, state_r == S_UPD, state_r == S_IDLE && !in_stall, "re-insert hung")

endmodule

FILE: rtl/sdol_cell.sv
module sdol_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sdol_pkg::cell_cmd_t cmd_i,
  input  sdol_pkg::entry_t   left_i,
  input  logic               left_b_i,
  input  sdol_pkg::entry_t   right_i,
  input  sdol_pkg::entry_t   head_i,
  input  logic               pre_i,
  output sdol_pkg::entry_t   ent_o,
  output logic               b_o,
  output logic               match_o
);
  import sdol_pkg::*;

  entry_t ent_r, ent_nxt;

  assign ent_o   = ent_r;
  assign match_o = ent_r.vld && (ent_r.slot == cmd_i.sel);
  assign b_o     = ent_r.vld &&
                   key_before(ent_r.layer, ent_r.seq, cmd_i.ins.layer, cmd_i.ins.seq);

  always_comb begin
    ent_nxt = ent_r;
    case (cmd_i.op)
      C_INSERT: begin
        // entries ahead of the new key stay, the first one behind takes it
        if (!b_o) begin
          ent_nxt = left_b_i ? cmd_i.ins : left_i;
        end
      end
      C_REMOVE: begin
        if (pre_i) begin
          ent_nxt = right_i;
        end
      end
      C_SETTEX: begin
        if (match_o) begin
          ent_nxt.tex = cmd_i.ins.tex;
        end
      end
      C_ROTATE: begin
        // tail of the list wraps the head around
        if (ent_r.vld && !right_i.vld) begin
          ent_nxt = head_i;
        end else begin
          ent_nxt = right_i;
        end
      end
      C_CLEAR: begin
        ent_nxt.vld = 1'b0;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

FILE: rtl/sdol_chain.sv
module sdol_chain #(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdol_pkg::cell_cmd_t cmd_i,
  output sdol_pkg::entry_t    head_o,
  output sdol_pkg::lookup_t   look_o
);
  import sdol_pkg::*;

  localparam int LVL = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  entry_t           ent   [SLOTS];
  logic [SLOTS-1:0] bflag;
  logic [SLOTS-1:0] match;
  logic [SLOTS-1:0] pf    [LVL+1];

  // prefix OR of the match flags: cell i at or behind the matching cell
  assign pf[0] = match;
  for (genvar l = 0; l < LVL; l++) begin : g_pre
    for (genvar i = 0; i < SLOTS; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pf[l+1][i] = pf[l][i] | pf[l][i-(1<<l)];
      end else begin : g_pass
        assign pf[l+1][i] = pf[l][i];
      end
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_b;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = ent[i-1];
      assign left_b = bflag[i-1];
    end
    if (i == SLOTS-1) begin : g_last
      assign right_e = '0;
    end else begin : g_nlast
      assign right_e = ent[i+1];
    end
    sdol_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd_i   (cmd_i),
      .left_i  (left_e),
      .left_b_i(left_b),
      .right_i (right_e),
      .head_i  (ent[0]),
      .pre_i   (pf[LVL][i]),
      .ent_o   (ent[i]),
      .b_o     (bflag[i]),
      .match_o (match[i])
    );
  end

  assign head_o = ent[0];

  // at most one cell matches: AND-OR select of its fields
  always_comb begin
    look_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) begin
        look_o.hit   = 1'b1;
        look_o.layer = look_o.layer | ent[i].layer;
        look_o.seq   = look_o.seq | ent[i].seq;
        look_o.tex   = look_o.tex | ent[i].tex;
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sdol_pkg::*;

  localparam int NSLOTS      = 64;
  localparam int HOLD_CYCLES = 300;   // long output hold-off for the pressure test
  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 8;     // settle time after the last word

  // opcodes the block does not know
  localparam logic [2:0] OP_BAD_A = 3'd6;
  localparam logic [2:0] OP_BAD_B = 3'd7;

  // one output word as the predictor expects it
  typedef struct {
    logic [1:0]         status;
    logic [5:0]         slot;
    logic [4:0]         tex;
    logic signed [15:0] layer;
    logic               last;
  } sprite_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_opcode = '0;
  logic [5:0]         in_slot_in = '0;
  logic [4:0]         in_texture_in = '0;
  logic signed [15:0] in_layer_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [5:0]         out_slot_out;
  logic [4:0]         out_texture_out;
  logic signed [15:0] out_layer_out;
  logic               out_last;

  sprite_draw_order_list_top #(.SLOTS(NSLOTS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_slot_in     (in_slot_in),
    .in_texture_in  (in_texture_in),
    .in_layer_in    (in_layer_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_texture_out(out_texture_out),
    .out_layer_out  (out_layer_out),
    .out_last       (out_last)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the sprite table and the draw order.
  // order_q holds used slots, lowest layer first, ties by older stamp.
  // ---------------------------------------------------------------------------
  logic               slot_used  [NSLOTS];
  logic signed [15:0] slot_layer [NSLOTS];
  logic [31:0]        slot_stamp [NSLOTS];
  logic [4:0]         slot_tex   [NSLOTS];
  logic [5:0]         order_q[$];
  logic [31:0]        next_stamp;

  sprite_word_t       due_words[$];   // words still owed by the block

  int mismatches   = 0;
  int words_seen   = 0;
  int idle_pct     = 0;    // sender gap odds, percent per cycle
  int stall_pct    = 0;    // receiver stall odds, percent per cycle
  int holds_asked  = 0;    // bumped by a test to request a long hold-off

  function automatic void wipe_tables();
    for (int i = 0; i < NSLOTS; i++) begin
      slot_used[i]  = 1'b0;
      slot_layer[i] = '0;
      slot_stamp[i] = '0;
      slot_tex[i]   = '0;
    end
    order_q.delete();
    next_stamp = '0;
  endfunction

  // a sorts strictly ahead of b in draw order
  function automatic bit stamp_before(input logic [5:0] a, input logic [5:0] b);
    if (slot_layer[a] != slot_layer[b]) return slot_layer[a] < slot_layer[b];
    return slot_stamp[a] < slot_stamp[b];
  endfunction

  function automatic void order_insert(input logic [5:0] s);
    int idx;
    idx = order_q.size();
    while (idx > 0 && !stamp_before(order_q[idx-1], s)) idx--;
    order_q.insert(idx, s);
  endfunction

  function automatic void order_drop(input logic [5:0] s);
    for (int i = 0; i < order_q.size(); i++) begin
      if (order_q[i] == s) begin
        order_q.delete(i);
        return;
      end
    end
  endfunction

  function automatic void push_word(input status_t st, input logic [5:0] s,
                                    input logic [4:0] t, input logic signed [15:0] l,
                                    input logic last);
    sprite_word_t w;
    w.status = st;
    w.slot   = s;
    w.tex    = t;
    w.layer  = l;
    w.last   = last;
    due_words.push_back(w);
  endfunction

  // Apply one accepted command to the shadow state and queue its words.
  function automatic void apply_sprite_cmd(input logic [2:0] op, input logic [5:0] slot,
                                           input logic [4:0] tex,
                                           input logic signed [15:0] layer);
    int  free_slot;
    bit  slot_ok;
    bit  tex_ok;
    free_slot = -1;
    slot_ok   = (slot < NSLOTS) && slot_used[slot];
    tex_ok    = (tex < TEXTURES);
    case (op)
      OP_ADD: begin
        for (int i = NSLOTS - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
        if (free_slot < 0 || !tex_ok) begin
          push_word(ST_FAIL, '0, '0, '0, 1'b1);
        end else begin
          slot_used[free_slot]  = 1'b1;
          slot_tex[free_slot]   = tex;
          slot_stamp[free_slot] = next_stamp;
          slot_layer[free_slot] = layer;
          next_stamp            = next_stamp + 32'd1;
          order_insert(free_slot[5:0]);
          push_word(ST_OK, free_slot[5:0], '0, '0, 1'b1);
        end
      end
      OP_UPDATE: begin
        if (!slot_ok) begin
          push_word(ST_FAIL, '0, '0, '0, 1'b1);
        end else begin
          if (slot_layer[slot] != layer) begin
            slot_layer[slot] = layer;
            order_drop(slot);
            order_insert(slot);
          end
          push_word(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      OP_SETTEX: begin
        if (!slot_ok || !tex_ok) begin
          push_word(ST_FAIL, '0, '0, '0, 1'b1);
        end else begin
          slot_tex[slot] = tex;
          push_word(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (!slot_ok) begin
          push_word(ST_FAIL, '0, '0, '0, 1'b1);
        end else begin
          order_drop(slot);
          slot_used[slot]  = 1'b0;
          slot_layer[slot] = '0;
          slot_stamp[slot] = '0;
          slot_tex[slot]   = '0;
          push_word(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      OP_CLEAR: begin
        wipe_tables();
        push_word(ST_OK, '0, '0, '0, 1'b1);
      end
      OP_DRAW: begin
        if (order_q.size() == 0) begin
          push_word(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          foreach (order_q[i]) begin
            push_word(ST_OK, order_q[i], slot_tex[order_q[i]], slot_layer[order_q[i]],
                      i == order_q.size() - 1);
          end
        end
      end
      default: push_word(ST_FAIL, '0, '0, '0, 1'b1);
    endcase
  endfunction

  initial wipe_tables();

  // ---------------------------------------------------------------------------
  // Mismatch log: one line per problem.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("ERROR word %0d: %s got %0h want %0h", words_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge that took the word.
  // A random gap drops valid first; valid is never lowered and raised in
  // the same step, so back-to-back words keep it high.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [2:0] op, input logic [5:0] slot,
                           input logic [4:0] tex, input logic signed [15:0] layer);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_slot_in    <= slot;
    in_texture_in <= tex;
    in_layer_in   <= layer;
    do @(posedge clk); while (in_stall);
    apply_sprite_cmd(op, slot, tex, layer);
  endtask

  // Stop offering and wait for every owed word, then let the block settle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long counted hold-off when a test asks.
  // ---------------------------------------------------------------------------
  int holds_done = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left  <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each taken word against the oldest expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sprite_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word, status", out_status, '0);
      end else begin
        want = due_words.pop_front();
        if (out_status !== want.status)     report_mismatch("status", out_status, want.status);
        if (out_slot_out !== want.slot)     report_mismatch("slot", out_slot_out, want.slot);
        if (out_texture_out !== want.tex)   report_mismatch("texture", out_texture_out, want.tex);
        if (out_layer_out !== want.layer)   report_mismatch("layer", out_layer_out, want.layer);
        if (out_last !== want.last)         report_mismatch("last", out_last, want.last);
      end
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sprite_draw_order_list_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] pick_layer();
    logic signed [15:0] l;
    case ($urandom_range(3))
      0:       l = 16'($urandom_range(6)) - 16'sd3;   // crowd a few layers for ties
      1:       l = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: l = 16'($urandom);
    endcase
    return l;
  endfunction

  // mostly a live slot so commands get past the lookup
  function automatic logic [5:0] pick_used_slot();
    if (order_q.size() == 0) return 6'($urandom_range(NSLOTS - 1));
    return order_q[$urandom_range(order_q.size() - 1)];
  endfunction

  task automatic random_item();
    int                 pick;
    logic [5:0]         s;
    logic [4:0]         t;
    logic signed [15:0] l;
    pick = $urandom_range(99);
    s    = pick_used_slot();
    t    = 5'($urandom_range(31));
    l    = pick_layer();
    if (pick < 30) begin
      send_word(OP_ADD, 6'($urandom_range(63)), t, l);
    end else if (pick < 50) begin
      // now and then repeat the current layer so the list is left alone
      if ($urandom_range(3) == 0) l = slot_layer[s];
      send_word(OP_UPDATE, s, t, l);
    end else if (pick < 60) begin
      send_word(OP_SETTEX, s, t, l);
    end else if (pick < 72) begin
      send_word(OP_REMOVE, s, t, l);
    end else if (pick < 84) begin
      send_word(OP_DRAW, 6'($urandom_range(63)), t, l);
    end else if (pick < 87) begin
      send_word(OP_CLEAR, 6'($urandom_range(63)), t, l);
    end else if (pick < 95) begin
      // any slot at all, often an empty one
      send_word(3'($urandom_range(OP_UPDATE, OP_REMOVE)), 6'($urandom_range(63)), t, l);
    end else begin
      send_word($urandom_range(1) ? OP_BAD_A : OP_BAD_B, 6'($urandom_range(63)), t, l);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: error paths, field extremes, ties, keep-layer update.
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);        // empty list
    send_word(OP_UPDATE, 6'd5,  5'd0,  16'sd1);        // unused slot
    send_word(OP_SETTEX, 6'd63, 5'd31, 16'sd0);        // unused slot
    send_word(OP_REMOVE, 6'd0,  5'd0,  16'sd0);        // unused slot
    send_word(OP_BAD_A,  6'd63, 5'd31, 16'sh7fff);     // unknown opcodes
    send_word(OP_BAD_B,  6'd0,  5'd0,  16'sh8000);
    send_word(OP_ADD,    6'd63, 5'd31, 16'sh7fff);     // slot 0
    send_word(OP_ADD,    6'd0,  5'd0,  16'sh8000);     // slot 1
    send_word(OP_ADD,    6'd0,  5'd17, 16'sd0);        // slot 2
    send_word(OP_ADD,    6'd0,  5'd5,  16'sd0);        // slot 3, tie behind 2
    send_word(OP_ADD,    6'd0,  5'd9,  16'sh8000);     // slot 4, tie behind 1
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);
    send_word(OP_UPDATE, 6'd2,  5'd0,  16'sd0);        // same layer
    send_word(OP_UPDATE, 6'd0,  5'd0,  16'sh8000);     // oldest stamp goes first
    send_word(OP_UPDATE, 6'd3,  5'd0,  -16'sd1);
    send_word(OP_SETTEX, 6'd1,  5'd31, 16'sd0);
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);
    send_word(OP_REMOVE, 6'd2,  5'd0,  16'sd0);
    send_word(OP_REMOVE, 6'd0,  5'd0,  16'sd0);
    send_word(OP_ADD,    6'd0,  5'd3,  16'sd0);        // reuses slot 0
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);
    send_word(OP_CLEAR,  6'd0,  5'd0,  16'sd0);
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);        // empty again
    send_word(OP_ADD,    6'd0,  5'd1,  16'sd2);        // stamps restart
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);
    finish_phase();
  endtask

  // Fill every slot, overflow once, draw the full list, then free one, re-add and draw again.
  task automatic test_full_table();
    send_word(OP_CLEAR, 6'd0, 5'd0, 16'sd0);
    for (int i = 0; i < NSLOTS; i++) send_word(OP_ADD, 6'd0, 5'($urandom), pick_layer());
    send_word(OP_ADD,    6'd0,  5'd7,  16'sd0);        // table full
    send_word(OP_SETTEX, 6'd63, 5'd30, 16'sd0);
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);
    send_word(OP_UPDATE, 6'd10, 5'd0,  16'sh7fff);
    send_word(OP_REMOVE, 6'd0,  5'd0,  16'sd0);
    send_word(OP_ADD,    6'd0,  5'd2,  16'sh8000);
    send_word(OP_DRAW,   6'd0,  5'd0,  16'sd0);
    send_word(OP_CLEAR,  6'd0,  5'd0,  16'sd0);
    finish_phase();
  endtask

  task automatic test_random(input int count, input int gap_pct, input int hold_pct);
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    repeat (count) random_item();
    finish_phase();
  endtask

  // Long output hold-off while the sender keeps pushing, so the block
  // backs up into in_stall; a full pause, then a run with jitter on both sides.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    holds_asked <= holds_asked + 1;
    repeat (4) send_word(OP_ADD, 6'd0, 5'($urandom), pick_layer());
    send_word(OP_DRAW, 6'd0, 5'd0, 16'sd0);
    repeat (5) random_item();
    finish_phase();
    idle_pct  = 30;
    stall_pct = 30;
    repeat (10) random_item();
    finish_phase();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_random(8, 0, 0);       // back to back
    test_random(8, 82, 0);      // sparse input
    test_random(8, 0, 82);      // slow receiver
    test_random(8, 16, 16);     // light jitter both sides
    test_backpressure();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("sprite_draw_order_list_top: match");
    end else begin
      $display("sprite_draw_order_list_top: mismatch");
    end
    $finish;
  end

endmodule
